// File: rtl/osr_pkg.sv
// ----------------------------------------------------------------------------
// osr_pkg: shared types and constants of the search ROM step unit
// Field widths, codes and the result record of the bit decision logic.
// ----------------------------------------------------------------------------
package osr_pkg;

  localparam int unsigned PAT_W   = 64;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CMD_W   = 8;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ID_BITS = 64;

  localparam logic [CMD_W-1:0] CMD_RESET = 8'hF0;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BIT   = 1'b1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [POS_W-1:0] run_dev;
    logic             chosen;
    logic             collision;
    logic             final_bit;
  } dec_t;

endpackage

// File: rtl/onewire_search_rom_step_unit.sv
// The first result of an item is registered and appears in the cycle after it
// is accepted. One bit item per cycle while the output is not stalled; a start
// item is followed by the command bits, the final bit item by the search report.
// The input is ready only when the output is free and no burst is pending.
// Reset clears the search state and out valid; the command register gets 0xF0.
// ----------------------------------------------------------------------------
// onewire_search_rom_step_unit: 1-Wire search ROM engine
// Sends the search command, decides id bits, reports the found ROM or an error.
// ----------------------------------------------------------------------------
module onewire_search_rom_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,      // search_command
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_pattern[63:0], last_deviation[70:64], bit_a[71], bit_b[72], zero[79:73]
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tuser,    // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_bit[0], rom_pattern[64:1], new_deviation[71:65], error[72], zero[79:73]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,    // kind
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    BURST_NONE,
    BURST_CMD,
    BURST_REPORT
  } burst_e;

  localparam int unsigned PW = osr_pkg::PAT_W;
  localparam int unsigned DW = osr_pkg::POS_W;

  logic [osr_pkg::CMD_W-1:0] cmd_q;
  logic [PW-1:0]             pattern_q, pattern_d;
  logic [DW-1:0]             pos_q, pos_d;
  logic [DW-1:0]             prev_dev_q, prev_dev_d;
  logic [DW-1:0]             run_dev_q, run_dev_d;
  logic                      active_q, active_d;
  burst_e                    burst_q, burst_d;
  logic [2:0]                cmd_idx_q, cmd_idx_d;

  logic                      out_valid_q, out_valid_d;
  logic                      out_kind_q, out_kind_d;
  logic                      out_wbit_q, out_wbit_d;
  logic                      out_last_q, out_last_d;
  logic [PW-1:0]             out_pat_q, out_pat_d;
  logic [DW-1:0]             out_dev_q, out_dev_d;
  logic                      out_err_q, out_err_d;

  logic                      out_free;
  logic                      in_accept;
  logic                      in_func;
  logic [PW-1:0]             in_pattern;
  logic [DW-1:0]             in_dev;
  logic                      in_a;
  logic                      in_b;
  osr_pkg::dec_t             dec;

  assign in_func    = s_axis_tuser;
  assign in_pattern = s_axis_tdata[63:0];
  assign in_dev     = s_axis_tdata[70:64];
  assign in_a       = s_axis_tdata[71];
  assign in_b       = s_axis_tdata[72];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (burst_q == BURST_NONE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  osr_bit_decide u_decide (
    .pattern_i  (pattern_q),
    .pos_i      (pos_q),
    .prev_dev_i (prev_dev_q),
    .run_dev_i  (run_dev_q),
    .bit_a_i    (in_a),
    .bit_b_i    (in_b),
    .dec_o      (dec)
  );

  always_comb begin
    pattern_d   = pattern_q;
    pos_d       = pos_q;
    prev_dev_d  = prev_dev_q;
    run_dev_d   = run_dev_q;
    active_d    = active_q;
    burst_d     = burst_q;
    cmd_idx_d   = cmd_idx_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_wbit_d  = out_wbit_q;
    out_last_d  = out_last_q;
    out_pat_d   = out_pat_q;
    out_dev_d   = out_dev_q;
    out_err_d   = out_err_q;

    if (out_free) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      out_kind_d = osr_pkg::KIND_WRITE;
      out_wbit_d = 1'b0;
      out_last_d = 1'b1;
      out_pat_d  = '0;
      out_dev_d  = '0;
      out_err_d  = 1'b0;
      if (in_func == osr_pkg::FUNC_START) begin
        pattern_d   = in_pattern;
        prev_dev_d  = in_dev;
        pos_d       = DW'(1);
        run_dev_d   = '0;
        active_d    = 1'b1;
        out_valid_d = 1'b1;
        out_wbit_d  = cmd_q[0];
        out_last_d  = 1'b0;
        cmd_idx_d   = 3'd1;
        burst_d     = BURST_CMD;
      end else if (active_q) begin
        out_valid_d = 1'b1;
        if (dec.collision) begin
          active_d   = 1'b0;
          out_kind_d = osr_pkg::KIND_REPORT;
          out_pat_d  = pattern_q;
          out_err_d  = 1'b1;
        end else begin
          pattern_d  = dec.pattern;
          run_dev_d  = dec.run_dev;
          out_wbit_d = dec.chosen;
          if (dec.final_bit) begin
            active_d   = 1'b0;
            out_last_d = 1'b0;
            burst_d    = BURST_REPORT;
          end else begin
            pos_d = pos_q + DW'(1);
          end
        end
      end
    end else if (out_free) begin
      unique case (burst_q)
        BURST_CMD: begin
          out_valid_d = 1'b1;
          out_kind_d  = osr_pkg::KIND_WRITE;
          out_wbit_d  = cmd_q[cmd_idx_q];
          out_last_d  = (cmd_idx_q == 3'd7);
          out_pat_d   = '0;
          out_dev_d   = '0;
          out_err_d   = 1'b0;
          cmd_idx_d   = cmd_idx_q + 3'd1;
          if (cmd_idx_q == 3'd7) begin
            burst_d = BURST_NONE;
          end
        end
        BURST_REPORT: begin
          out_valid_d = 1'b1;
          out_kind_d  = osr_pkg::KIND_REPORT;
          out_wbit_d  = 1'b0;
          out_last_d  = 1'b1;
          out_pat_d   = pattern_q;
          out_dev_d   = run_dev_q;
          out_err_d   = 1'b0;
          burst_d     = BURST_NONE;
        end
        default: begin
          burst_d = BURST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= osr_pkg::CMD_RESET;
      pattern_q   <= '0;
      pos_q       <= DW'(1);
      prev_dev_q  <= '0;
      run_dev_q   <= '0;
      active_q    <= 1'b0;
      burst_q     <= BURST_NONE;
      cmd_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cmd_q <= cfg_data_i;
      end
      pattern_q   <= pattern_d;
      pos_q       <= pos_d;
      prev_dev_q  <= prev_dev_d;
      run_dev_q   <= run_dev_d;
      active_q    <= active_d;
      burst_q     <= burst_d;
      cmd_idx_q   <= cmd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_wbit_q <= out_wbit_d;
    out_last_q <= out_last_d;
    out_pat_q  <= out_pat_d;
    out_dev_q  <= out_dev_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_err_q, out_dev_q, out_pat_q, out_wbit_q};

endmodule

// File: rtl/osr_bit_decide.sv
// ----------------------------------------------------------------------------
// osr_bit_decide: direction choice for one search ROM bit
// Applies the discrepancy rules to one id/complement pair and returns the
// updated pattern, running deviation, chosen bit and collision/final flags.
// ----------------------------------------------------------------------------
module osr_bit_decide (
  input  logic [osr_pkg::PAT_W-1:0] pattern_i,
  input  logic [osr_pkg::POS_W-1:0] pos_i,
  input  logic [osr_pkg::POS_W-1:0] prev_dev_i,
  input  logic [osr_pkg::POS_W-1:0] run_dev_i,
  input  logic                      bit_a_i,
  input  logic                      bit_b_i,
  output osr_pkg::dec_t             dec_o
);

  logic [osr_pkg::POS_W-1:0] pos_m1;
  logic [osr_pkg::IDX_W-1:0] idx;
  logic                      cur_bit;
  logic                      new_bit;
  logic [osr_pkg::POS_W-1:0] run_dev;

  assign pos_m1  = pos_i - osr_pkg::POS_W'(1);
  assign idx     = pos_m1[osr_pkg::IDX_W-1:0];
  assign cur_bit = pattern_i[idx];

  always_comb begin
    run_dev = run_dev_i;
    if (bit_a_i != bit_b_i) begin
      new_bit = bit_a_i;
    end else if (pos_i == prev_dev_i) begin
      new_bit = 1'b1;
    end else if (pos_i > prev_dev_i) begin
      new_bit = 1'b0;
      run_dev = pos_i;
    end else begin
      new_bit = cur_bit;
      if (!cur_bit) begin
        run_dev = pos_i;
      end
    end
  end

  always_comb begin
    dec_o.pattern      = pattern_i;
    dec_o.pattern[idx] = new_bit;
    dec_o.run_dev      = run_dev;
    dec_o.chosen       = new_bit;
    dec_o.collision    = bit_a_i & bit_b_i;
    dec_o.final_bit    = (pos_i >= osr_pkg::POS_W'(osr_pkg::ID_BITS));
  end

endmodule

// File: dv/osr_search_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osr_search_checker: result predictor and comparator for the search ROM unit
// Watches the command, input and result channels, predicts every result from
// its own model of the discrepancy search, and compares results in order.
// ----------------------------------------------------------------------------
module osr_search_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [osr_pkg::CMD_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  // start_pattern[63:0], last_deviation[70:64], bit_a[71], bit_b[72], zero[79:73]
  input  logic [79:0]               in_data_i,
  input  logic                      in_user_i,     // func
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  // write_bit[0], rom_pattern[64:1], new_deviation[71:65], error[72], zero[79:73]
  input  logic [79:0]               out_data_i,
  input  logic                      out_user_i,    // kind
  input  logic                      out_last_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               outstanding_o,
  output int unsigned               results_o,
  output int unsigned               reports_o,
  output int unsigned               errors_o
);

  typedef struct packed {
    logic                      kind;
    logic                      write_bit;
    logic                      last;
    logic [osr_pkg::PAT_W-1:0] rom_pattern;
    logic [osr_pkg::POS_W-1:0] new_deviation;
    logic                      error;
  } bus_result_t;

  bus_result_t               awaited[$];
  logic [osr_pkg::CMD_W-1:0] command_byte;
  logic [osr_pkg::PAT_W-1:0] rom_guess;
  logic [osr_pkg::POS_W-1:0] bit_index;
  logic [osr_pkg::POS_W-1:0] prior_dev;
  logic [osr_pkg::POS_W-1:0] newest_dev;
  logic                      searching;

  function automatic bus_result_t bus_write(input logic value, input logic final_one);
    bus_result_t r;
    r = '0;
    r.kind = osr_pkg::KIND_WRITE;
    r.write_bit = value;
    r.last = final_one;
    return r;
  endfunction

  function automatic bus_result_t search_report(input logic [osr_pkg::PAT_W-1:0] rom,
                                                input logic [osr_pkg::POS_W-1:0] dev,
                                                input logic failed);
    bus_result_t r;
    r = '0;
    r.kind = osr_pkg::KIND_REPORT;
    r.last = 1'b1;
    r.rom_pattern = rom;
    r.new_deviation = dev;
    r.error = failed;
    return r;
  endfunction

  task automatic advance_search(input logic func,
                                input logic [osr_pkg::PAT_W-1:0] pattern,
                                input logic [osr_pkg::POS_W-1:0] deviation,
                                input logic id_bit, input logic cmp_bit);
    logic [osr_pkg::PAT_W-1:0] one_hot;
    logic                      chosen;
    if (func == osr_pkg::FUNC_START) begin
      rom_guess = pattern;
      prior_dev = deviation;
      bit_index = 7'd1;
      newest_dev = '0;
      searching = 1'b1;
      for (int i = 0; i < osr_pkg::CMD_W; i++) begin
        awaited.push_back(bus_write(command_byte[i], i == osr_pkg::CMD_W - 1));
      end
    end else if (searching) begin
      if (id_bit && cmp_bit) begin
        searching = 1'b0;
        awaited.push_back(search_report(rom_guess, '0, 1'b1));
      end else begin
        one_hot = osr_pkg::PAT_W'(1) << (bit_index - 7'd1);
        // The 0/0 case is a discrepancy: follow the earlier path below the
        // previous deviation, take 1 at it and 0 beyond it.
        if (id_bit != cmp_bit) begin
          rom_guess = id_bit ? (rom_guess | one_hot) : (rom_guess & ~one_hot);
        end else if (bit_index == prior_dev) begin
          rom_guess = rom_guess | one_hot;
        end else if (bit_index > prior_dev) begin
          rom_guess = rom_guess & ~one_hot;
          newest_dev = bit_index;
        end else if ((rom_guess & one_hot) == '0) begin
          newest_dev = bit_index;
        end
        chosen = |(rom_guess & one_hot);
        if (bit_index >= osr_pkg::ID_BITS) begin
          searching = 1'b0;
          awaited.push_back(bus_write(chosen, 1'b0));
          awaited.push_back(search_report(rom_guess, newest_dev, 1'b0));
        end else begin
          bit_index = bit_index + 7'd1;
          awaited.push_back(bus_write(chosen, 1'b1));
        end
      end
    end
  endtask

  task automatic compare_result(input bus_result_t got);
    bus_result_t want;
    string       diff;
    diff = "";
    want = '0;
    results_o++;
    if (got.kind == osr_pkg::KIND_REPORT) reports_o++;
    if (got.error) errors_o++;
    if (awaited.size() == 0) begin
      diff = " no result was due";
    end else begin
      want = awaited.pop_front();
      if (got.kind !== want.kind) diff = {diff, " kind"};
      if (got.write_bit !== want.write_bit) diff = {diff, " write_bit"};
      if (got.last !== want.last) diff = {diff, " last"};
      if (got.rom_pattern !== want.rom_pattern) diff = {diff, " rom_pattern"};
      if (got.new_deviation !== want.new_deviation) diff = {diff, " new_deviation"};
      if (got.error !== want.error) diff = {diff, " error"};
    end
    if (diff != "") begin
      if (mismatch_count_o < 10) begin
        $display("[%0t] result mismatch:%s", $time, diff);
        $display("  expected kind=%0b bit=%0b last=%0b rom=%h dev=%0d err=%0b",
                 want.kind, want.write_bit, want.last, want.rom_pattern,
                 want.new_deviation, want.error);
        $display("  actual   kind=%0b bit=%0b last=%0b rom=%h dev=%0d err=%0b",
                 got.kind, got.write_bit, got.last, got.rom_pattern,
                 got.new_deviation, got.error);
      end
      mismatch_count_o++;
    end
  endtask

  // Results are taken before new inputs, since an input accepted at this edge
  // cannot produce a result at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited.delete();
      command_byte = osr_pkg::CMD_RESET;
      rom_guess = '0;
      bit_index = 7'd1;
      prior_dev = '0;
      newest_dev = '0;
      searching = 1'b0;
      mismatch_count_o = 0;
      outstanding_o = 0;
      results_o = 0;
      reports_o = 0;
      errors_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_result('{kind: out_user_i, write_bit: out_data_i[0], last: out_last_i,
                         rom_pattern: out_data_i[64:1], new_deviation: out_data_i[71:65],
                         error: out_data_i[72]});
      end
      if (cfg_valid_i && cfg_ready_i) command_byte = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        advance_search(in_user_i, in_data_i[63:0], in_data_i[70:64], in_data_i[71],
                       in_data_i[72]);
      end
      outstanding_o = awaited.size();
    end
  end

endmodule

// File: dv/onewire_search_rom_step_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// onewire_search_rom_step_unit_tb: stimulus and verdict for the search unit
// Drives directed and random searches under several command bytes with random
// gaps on both sides and one long output stall; a checker compares results.
// ----------------------------------------------------------------------------
module onewire_search_rom_step_unit_tb;

  localparam int unsigned ITEM_TARGET  = 430;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES  = 12;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [osr_pkg::CMD_W-1:0] cfg_data_i = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [79:0]               s_axis_tdata = '0;
  logic                      s_axis_tuser = osr_pkg::FUNC_START;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [79:0]               m_axis_tdata;
  logic                      m_axis_tuser;
  logic                      m_axis_tlast;

  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       results_seen;
  int unsigned       reports_seen;
  int unsigned       errors_seen;
  int unsigned       items_accepted = 0;
  int unsigned       settings_used = 0;
  logic              send_calm = 1'b1;
  logic              sink_calm = 1'b0;

  onewire_search_rom_step_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  osr_search_checker search_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .out_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .results_o        (results_seen),
    .reports_o        (reports_seen),
    .errors_o         (errors_seen)
  );

  initial begin : clock_gen
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #500000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int unsigned pause_len(input logic calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_item(input logic func, input logic [osr_pkg::PAT_W-1:0] pattern,
                           input logic [osr_pkg::POS_W-1:0] deviation,
                           input logic id_bit, input logic cmp_bit);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = pause_len(send_calm);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {7'b0, cmp_bit, id_bit, deviation, pattern};
    do @(posedge clk_i); while (!s_axis_tready);
    items_accepted++;
  endtask

  task automatic start_search(input logic [osr_pkg::PAT_W-1:0] pattern,
                              input logic [osr_pkg::POS_W-1:0] deviation);
    send_item(osr_pkg::FUNC_START, pattern, deviation, 1'b0, 1'b0);
  endtask

  task automatic bit_pair(input logic id_bit, input logic cmp_bit);
    send_item(osr_pkg::FUNC_BIT, {$urandom, $urandom}, osr_pkg::POS_W'($urandom),
              id_bit, cmp_bit);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_command(input logic [osr_pkg::CMD_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_search(input int unsigned limit);
    logic [osr_pkg::POS_W-1:0] deviation;
    int unsigned               style;
    int unsigned               stop_at;
    int unsigned               pick;
    logic                      id_bit;
    logic                      cmp_bit;
    case ($urandom_range(0, 9))
      0: deviation = '0;
      1: deviation = osr_pkg::POS_W'(osr_pkg::ID_BITS);
      2: deviation = osr_pkg::POS_W'($urandom_range(65, 127));
      default: deviation = osr_pkg::POS_W'($urandom_range(1, 63));
    endcase
    // Most searches run to the last bit; some end on a 1/1 pair and some are
    // abandoned by the next start.
    style = $urandom_range(0, 9);
    stop_at = (style < 6) ? osr_pkg::ID_BITS : $urandom_range(1, osr_pkg::ID_BITS);
    start_search({$urandom, $urandom}, deviation);
    for (int unsigned pos = 1; pos <= stop_at; pos++) begin
      if (items_accepted >= limit) break;
      if (style >= 8 && pos == stop_at) break;
      if (style >= 6 && pos == stop_at) begin
        {id_bit, cmp_bit} = 2'b11;
      end else begin
        pick = $urandom_range(0, 9);
        {id_bit, cmp_bit} = (pick < 3) ? 2'b00 : (pick < 6) ? 2'b01 : 2'b10;
      end
      bit_pair(id_bit, cmp_bit);
    end
  endtask

  initial begin : sink
    int unsigned gap;
    logic        held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      gap = pause_len(sink_calm);
      if (!held && results_seen >= 150) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    logic [osr_pkg::CMD_W-1:0] command_plan [PHASES];
    int unsigned               phase_limit;
    command_plan[0] = 8'h00;
    command_plan[1] = 8'hFF;
    command_plan[2] = osr_pkg::CMD_W'($urandom);
    command_plan[3] = osr_pkg::CMD_RESET;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    bit_pair(1'b1, 1'b1);
    start_search('1, 7'd127);
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b0, 1'b1);
    bit_pair(1'b1, 1'b0);
    bit_pair(1'b0, 1'b0);
    start_search('0, 7'd2);
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b1, 1'b1);
    bit_pair(1'b0, 1'b0);
    start_search({$urandom, $urandom}, '0);
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b1, 1'b0);
    start_search({$urandom, $urandom}, osr_pkg::POS_W'(osr_pkg::ID_BITS));
    bit_pair(1'b0, 1'b0);
    bit_pair(1'b1, 1'b1);

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      write_command(command_plan[p]);
      phase_limit = (p + 1) * ITEM_TARGET / PHASES;
      while (items_accepted < phase_limit) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 2)) bit_pair(1'($urandom), 1'($urandom));
        end
        random_search(phase_limit);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Drove %0d input transactions under %0d written command bytes.",
             items_accepted, settings_used);
    $display("Checked %0d results, %0d of them search reports and %0d with error set.",
             results_seen, reports_seen, errors_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
